// ===== src/ffba_pkg.sv =====
// Shared types, constants and helpers of the first-fit block allocator.
package ffba_pkg;

  // Geometry defaults and fixed field widths
  localparam int NUM_BLOCKS_DEF = 1024;
  localparam int MAX_RUN_DEF    = 256;
  localparam int RESV_RST       = 32;
  localparam int WORD_W         = 8;
  localparam int RESV_W         = 10;
  localparam int CNT_W          = 9;
  localparam int START_W        = 10;
  localparam int FC_W           = 11;

  // Operation codes
  localparam logic FN_ALLOC = 1'b0;
  localparam logic FN_FREE  = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOMEM  = 2'd1,
    ST_NORUN  = 2'd2,
    ST_BADREL = 2'd3
  } status_t;

  // Outcome of scanning one map word
  typedef struct packed {
    logic             found;
    logic [2:0]       pos;
    logic [CNT_W-1:0] run;
  } scan_res_t;

  // Count set bits of one map word
  function automatic logic [3:0] popcount8(input logic [WORD_W-1:0] w);
    logic [3:0] n;
    n = '0;
    for (int k = 0; k < WORD_W; k++) begin
      n = n + {3'd0, w[k]};
    end
    return n;
  endfunction

endpackage

// ===== src/ffba_scan_step.sv =====
// One map word of the first-fit search: extends the free run bit by bit.
module ffba_scan_step #(
  parameter int NUM_BLOCKS = ffba_pkg::NUM_BLOCKS_DEF,
  parameter int XW         = 18
) (
  input  logic [ffba_pkg::WORD_W-1:0] word,
  input  logic [XW-1:0]               base,
  input  logic [XW-1:0]               lo,
  input  logic [ffba_pkg::CNT_W-1:0]  run_in,
  input  logic [ffba_pkg::CNT_W-1:0]  count,
  output ffba_pkg::scan_res_t         res
);

  // Walk the eight bits, blocks below the boundary or past the store count as used
  always_comb begin
    logic [ffba_pkg::CNT_W-1:0] run;
    logic [XW-1:0]              b;
    logic                       used;
    logic                       found;
    logic [2:0]                 pos;
    run   = run_in;
    found = 1'b0;
    pos   = '0;
    for (int k = 0; k < ffba_pkg::WORD_W; k++) begin
      b    = base + XW'(k);
      used = word[k] || (b < lo) || (b >= XW'(NUM_BLOCKS));
      if (!found) begin
        if (used) begin
          run = '0;
        end else begin
          run = run + 1'b1;
          if (run == count) begin
            found = 1'b1;
            pos   = 3'(k);
          end
        end
      end
    end
    res.found = found;
    res.pos   = pos;
    res.run   = run;
  end

endmodule

// ===== src/first_fit_block_allocator.sv =====
// First-fit allocator: FSM, block map memory and used-block counter.
// A rejected request goes straight to the result state; a release reads and then writes back
// each map word of its range before the result; an allocate scans map words upward from the
// floor (8 blocks each, one memory read a cycle), then reads and writes back each word it marks.
// Throughput: one transaction at a time; the next is taken the cycle after a result loads.
// Reset: synchronous; a clearing pass then zeroes the map, one word a cycle,
// with in_ready low; configuration writes are taken throughout.
module first_fit_block_allocator #(
  parameter int NUM_BLOCKS = ffba_pkg::NUM_BLOCKS_DEF,
  parameter int MAX_RUN    = ffba_pkg::MAX_RUN_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [ffba_pkg::RESV_W-1:0]  cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_func,
  input  logic [ffba_pkg::CNT_W-1:0]   in_count,
  input  logic [ffba_pkg::START_W-1:0] in_start_req,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   out_status,
  output logic [ffba_pkg::START_W-1:0] out_start_block,
  output logic [ffba_pkg::FC_W-1:0]    out_free_count
);

  localparam int WW  = ffba_pkg::WORD_W;
  localparam int NW  = (NUM_BLOCKS + WW - 1) / WW;
  localparam int AW  = $clog2(NW);
  localparam int BIW = AW + 3;
  localparam int BW1 = $clog2(NUM_BLOCKS + 1);
  localparam int XW  = (BIW > ffba_pkg::FC_W ? BIW : ffba_pkg::FC_W) + 1;

  typedef enum logic [5:0] {
    S_CLR     = 6'b000001,
    S_IDLE    = 6'b000010,
    S_SCAN    = 6'b000100,
    S_MARK_RD = 6'b001000,
    S_MARK_WR = 6'b010000,
    S_FIN     = 6'b100000
  } state_t;

  state_t                       state_r, state_nxt;
  logic [ffba_pkg::RESV_W-1:0]  reserved_r, reserved_nxt;
  logic [BW1-1:0]               used_r, used_nxt;
  logic [AW-1:0]                word_r, word_nxt;
  logic                         pend_r, pend_nxt;
  logic [AW-1:0]                pend_addr_r, pend_addr_nxt;
  logic [ffba_pkg::CNT_W-1:0]   run_r, run_nxt;
  logic [ffba_pkg::CNT_W-1:0]   count_r, count_nxt;
  logic [BIW-1:0]               m_lo_r, m_lo_nxt;
  logic [BIW-1:0]               m_hi_r, m_hi_nxt;
  logic [AW-1:0]                mw_r, mw_nxt;
  logic                         m_set_r, m_set_nxt;
  ffba_pkg::status_t            st_r, st_nxt;
  logic [ffba_pkg::START_W-1:0] sb_r, sb_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [1:0]                   out_status_r, out_status_nxt;
  logic [ffba_pkg::START_W-1:0] out_start_block_r, out_start_block_nxt;
  logic [ffba_pkg::FC_W-1:0]    out_free_count_r, out_free_count_nxt;

  // Block map memory
  logic [WW-1:0] mem [NW];
  logic [WW-1:0] rdata_r;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [WW-1:0] mem_wd;
  logic [AW-1:0] rd_addr;

  // Boundary and free count
  logic [XW-1:0]  resv_x;
  logic [XW-1:0]  lo_x;
  logic [BW1-1:0] lo;
  logic [BW1-1:0] avail;
  logic [BW1-1:0] free_blk;
  logic [XW-1:0]  free_x;
  logic [XW-1:0]  count_x;
  logic [XW-1:0]  start_x;
  logic [XW-1:0]  rel_end_x;
  logic           rel_bad;
  logic [XW-1:0]  found_end_x;
  logic [XW-1:0]  found_start_x;
  logic [XW-1:0]  scan_base_x;
  ffba_pkg::scan_res_t scan_res;
  logic [WW-1:0]  mark_mask;
  logic [3:0]     cleared;

  assign resv_x  = XW'(reserved_r);
  assign lo_x    = (resv_x > XW'(NUM_BLOCKS)) ? XW'(NUM_BLOCKS) : resv_x;
  assign lo      = lo_x[BW1-1:0];
  assign avail   = BW1'(NUM_BLOCKS) - lo;
  assign free_blk = (used_r >= avail) ? '0 : (avail - used_r);
  assign free_x  = XW'(free_blk);

  // Release range check on the incoming request
  assign count_x   = XW'(in_count);
  assign start_x   = XW'(in_start_req);
  assign rel_end_x = start_x + count_x;
  assign rel_bad   = (in_count == '0) || (count_x > XW'(MAX_RUN)) ||
                     (start_x < lo_x) || (rel_end_x > XW'(NUM_BLOCKS));

  // Search one word of the map per cycle
  assign scan_base_x = XW'({pend_addr_r, 3'd0});

  ffba_scan_step #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .XW         (XW)
  ) u_scan (
    .word   (rdata_r),
    .base   (scan_base_x),
    .lo     (lo_x),
    .run_in (run_r),
    .count  (count_r),
    .res    (scan_res)
  );

  assign found_end_x   = XW'({pend_addr_r, scan_res.pos});
  assign found_start_x = found_end_x + XW'(1) - XW'(count_r);

  // Bits of the current word that fall inside the marked range
  always_comb begin
    logic [BIW-1:0] b;
    for (int k = 0; k < WW; k++) begin
      b = {mw_r, 3'(k)};
      mark_mask[k] = (b >= m_lo_r) && (b <= m_hi_r);
    end
  end

  assign cleared = ffba_pkg::popcount8(rdata_r & mark_mask);

  // Next-state logic
  always_comb begin
    state_nxt           = state_r;
    reserved_nxt        = reserved_r;
    used_nxt            = used_r;
    word_nxt            = word_r;
    pend_nxt            = 1'b0;
    pend_addr_nxt       = pend_addr_r;
    run_nxt             = run_r;
    count_nxt           = count_r;
    m_lo_nxt            = m_lo_r;
    m_hi_nxt            = m_hi_r;
    mw_nxt              = mw_r;
    m_set_nxt           = m_set_r;
    st_nxt              = st_r;
    sb_nxt              = sb_r;
    out_valid_nxt       = out_valid_r && !out_ready;
    out_status_nxt      = out_status_r;
    out_start_block_nxt = out_start_block_r;
    out_free_count_nxt  = out_free_count_r;
    in_ready            = 1'b0;
    mem_we              = 1'b0;
    mem_wa              = mw_r;
    mem_wd              = '0;
    rd_addr             = mw_r;

    if (cfg_wr_en) begin
      reserved_nxt = cfg_wr_data;
    end

    unique case (state_r)
      // Zero the map one word a cycle
      S_CLR: begin
        mem_we = 1'b1;
        if (mw_r == AW'(NW - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          mw_nxt = mw_r + 1'b1;
        end
      end

      // Take a transaction and decide its path
      S_IDLE: begin
        in_ready  = 1'b1;
        count_nxt = in_count;
        sb_nxt    = '0;
        st_nxt    = ffba_pkg::ST_OK;
        if (in_valid) begin
          if (in_func == ffba_pkg::FN_ALLOC) begin
            if (count_x > free_x) begin
              st_nxt    = ffba_pkg::ST_NOMEM;
              state_nxt = S_FIN;
            end else if ((in_count == '0) || (count_x > XW'(MAX_RUN))) begin
              st_nxt    = ffba_pkg::ST_NORUN;
              state_nxt = S_FIN;
            end else begin
              word_nxt  = AW'(lo >> 3);
              run_nxt   = '0;
              state_nxt = S_SCAN;
            end
          end else begin
            if (rel_bad) begin
              st_nxt    = ffba_pkg::ST_BADREL;
              state_nxt = S_FIN;
            end else begin
              m_lo_nxt  = start_x[BIW-1:0];
              m_hi_nxt  = BIW'(rel_end_x - XW'(1));
              mw_nxt    = AW'(in_start_req >> 3);
              m_set_nxt = 1'b0;
              state_nxt = S_MARK_RD;
            end
          end
        end
      end

      // Issue the next word read and check the word that came back
      S_SCAN: begin
        rd_addr       = word_r;
        pend_nxt      = 1'b1;
        pend_addr_nxt = word_r;
        if (word_r != AW'(NW - 1)) begin
          word_nxt = word_r + 1'b1;
        end
        if (pend_r) begin
          run_nxt = scan_res.run;
          if (scan_res.found) begin
            m_lo_nxt  = found_start_x[BIW-1:0];
            m_hi_nxt  = found_end_x[BIW-1:0];
            mw_nxt    = found_start_x[BIW-1:3];
            m_set_nxt = 1'b1;
            used_nxt  = used_r + BW1'(count_r);
            sb_nxt    = found_start_x[ffba_pkg::START_W-1:0];
            pend_nxt  = 1'b0;
            state_nxt = S_MARK_RD;
          end else if (pend_addr_r == AW'(NW - 1)) begin
            st_nxt    = ffba_pkg::ST_NORUN;
            pend_nxt  = 1'b0;
            state_nxt = S_FIN;
          end
        end
      end

      // Read the word to update
      S_MARK_RD: begin
        rd_addr   = mw_r;
        state_nxt = S_MARK_WR;
      end

      // Set or clear the range bits and write back
      S_MARK_WR: begin
        mem_we = 1'b1;
        if (m_set_r) begin
          mem_wd = rdata_r | mark_mask;
        end else begin
          mem_wd   = rdata_r & ~mark_mask;
          used_nxt = (used_r > BW1'(cleared)) ? (used_r - BW1'(cleared)) : '0;
        end
        if (mw_r == m_hi_r[BIW-1:3]) begin
          state_nxt = S_FIN;
        end else begin
          mw_nxt    = mw_r + 1'b1;
          state_nxt = S_MARK_RD;
        end
      end

      // Load the result once the output register is free
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt       = 1'b1;
          out_status_nxt      = st_r;
          out_start_block_nxt = sb_r;
          out_free_count_nxt  = free_x[ffba_pkg::FC_W-1:0];
          state_nxt           = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Map memory ports
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata_r <= mem[rd_addr];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      reserved_r  <= ffba_pkg::RESV_W'(ffba_pkg::RESV_RST);
      used_r      <= '0;
      mw_r        <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      reserved_r  <= reserved_nxt;
      used_r      <= used_nxt;
      mw_r        <= mw_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and result payload registers
  always_ff @(posedge clk) begin
    word_r            <= word_nxt;
    pend_addr_r       <= pend_addr_nxt;
    run_r             <= run_nxt;
    count_r           <= count_nxt;
    m_lo_r            <= m_lo_nxt;
    m_hi_r            <= m_hi_nxt;
    m_set_r           <= m_set_nxt;
    st_r              <= st_nxt;
    sb_r              <= sb_nxt;
    out_status_r      <= out_status_nxt;
    out_start_block_r <= out_start_block_nxt;
    out_free_count_r  <= out_free_count_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_start_block = out_start_block_r;
  assign out_free_count  = out_free_count_r;

endmodule

// ===== src/ffba_chk.sv =====
// Port checker of the first-fit block allocator and its bind.
module ffba_chk #(
  parameter int NUM_BLOCKS = ffba_pkg::NUM_BLOCKS_DEF
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [1:0]                   out_status,
  input logic [ffba_pkg::START_W-1:0] out_start_block,
  input logic [ffba_pkg::FC_W-1:0]    out_free_count
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
    $stable(out_start_block) && $stable(out_free_count))
    else $error("stalled result changed");

  // A failed transaction reports start block zero
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ffba_pkg::ST_OK) |-> out_start_block == '0)
    else $error("failed transaction with nonzero start block");

  // Free count never exceeds the store
  a_free_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(out_free_count) <= NUM_BLOCKS)
    else $error("free count beyond store size");

  // One transaction in work at a time
  a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

endmodule

bind first_fit_block_allocator ffba_chk #(.NUM_BLOCKS(NUM_BLOCKS)) u_ffba_chk (.*);

// ===== tb/testbench.sv =====
// Self-checking testbench for the first-fit block allocator with a built-in allocation map.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NBLK = ffba_pkg::NUM_BLOCKS_DEF;
  localparam int MAXR = ffba_pkg::MAX_RUN_DEF;
  localparam int CW   = ffba_pkg::CNT_W;
  localparam int SW   = ffba_pkg::START_W;
  localparam int FW   = ffba_pkg::FC_W;
  localparam int RW   = ffba_pkg::RESV_W;

  typedef struct packed {
    ffba_pkg::status_t    status;
    logic [SW-1:0]        first;
    logic [FW-1:0]        free_cnt;
  } alloc_result_t;

  typedef struct {
    int unsigned first;
    int unsigned len;
  } run_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_wr_en;
  logic [RW-1:0]       cfg_wr_data;
  logic                in_valid;
  logic                in_ready;
  logic                in_func;
  logic [CW-1:0]       in_count;
  logic [SW-1:0]       in_start_req;
  logic                out_valid;
  logic                out_ready;
  logic [1:0]          out_status;
  logic [SW-1:0]       out_start_block;
  logic [FW-1:0]       out_free_count;

  // Mirror of the allocator state
  bit                  blk_used [NBLK];
  int unsigned         used_blocks;
  int unsigned         reserved_cfg;

  alloc_result_t       expected_q [$];
  run_t                granted [$];
  bit                  no_gaps;
  int                  rx_hold_cycles;
  int                  mismatches;

  first_fit_block_allocator dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_func         (in_func),
    .in_count        (in_count),
    .in_start_req    (in_start_req),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_start_block (out_start_block),
    .out_free_count  (out_free_count)
  );

  // Free-running clock
  always #1 clk = ~clk;

  function automatic int draw_gap();
    return no_gaps ? 0 : int'($urandom_range(0, 5));
  endfunction

  function automatic int unsigned alloc_floor();
    return (reserved_cfg > NBLK) ? NBLK : reserved_cfg;
  endfunction

  function automatic int unsigned free_now();
    int unsigned avail;
    avail = NBLK - alloc_floor();
    return (used_blocks >= avail) ? 0 : avail - used_blocks;
  endfunction

  // Apply one request to the mirror and return the answer the allocator owes
  function automatic alloc_result_t predict_result(logic fn, logic [CW-1:0] cnt,
                                                   logic [SW-1:0] st);
    alloc_result_t r;
    int unsigned   n;
    int unsigned   s;
    int unsigned   lo;
    int unsigned   run;
    int unsigned   hit;
    bit            found;
    n = 32'(cnt);
    s = 32'(st);
    lo = alloc_floor();
    r.status = ffba_pkg::ST_OK;
    r.first = '0;
    run = 0;
    hit = 0;
    found = 1'b0;
    if (fn == ffba_pkg::FN_ALLOC) begin
      if (n > free_now()) begin
        r.status = ffba_pkg::ST_NOMEM;
      end else if (n == 0 || n > MAXR) begin
        r.status = ffba_pkg::ST_NORUN;
      end else begin
        // first fit: lowest run of n free blocks at or above the floor
        for (int unsigned i = lo; i < NBLK && !found; i++) begin
          if (blk_used[i]) begin
            run = 0;
          end else begin
            run++;
            if (run == n) begin
              found = 1'b1;
              hit = i;
            end
          end
        end
        if (found) begin
          for (int unsigned i = hit + 1 - n; i <= hit; i++) blk_used[i] = 1'b1;
          used_blocks += n;
          r.first = SW'(hit + 1 - n);
        end else begin
          r.status = ffba_pkg::ST_NORUN;
        end
      end
    end else begin
      if (n == 0 || n > MAXR || s < lo || s + n > NBLK) begin
        r.status = ffba_pkg::ST_BADREL;
      end else begin
        // count only blocks that were really in use
        for (int unsigned i = s; i < s + n; i++) begin
          if (blk_used[i]) begin
            blk_used[i] = 1'b0;
            if (used_blocks > 0) used_blocks--;
          end
        end
      end
    end
    r.free_cnt = FW'(free_now());
    return r;
  endfunction

  // Offer one request after a random gap and log its expected answer on acceptance
  task automatic send_item(logic fn, logic [CW-1:0] cnt, logic [SW-1:0] st,
                           output alloc_result_t res);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_func      <= fn;
    in_count     <= cnt;
    in_start_req <= st;
    do @(posedge clk); while (in_ready !== 1'b1);
    res = predict_result(fn, cnt, st);
    expected_q.push_back(res);
  endtask

  // Drop valid and hold until every outstanding answer is back
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_q.size() != 0);
  endtask

  task automatic set_reserved(logic [RW-1:0] v);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    reserved_cfg = 32'(v);
  endtask

  task automatic return_all_runs();
    alloc_result_t r;
    run_t          rr;
    while (granted.size() != 0) begin
      rr = granted.pop_front();
      send_item(ffba_pkg::FN_FREE, CW'(rr.len), SW'(rr.first), r);
    end
  endtask

  // One request: mostly allocations and returns of granted runs, some junk
  task automatic random_item();
    alloc_result_t      r;
    run_t               rr;
    int                 sel;
    int                 k;
    logic [CW-1:0]      n;
    logic [SW-1:0]      s;
    sel = int'($urandom_range(0, 99));
    if (sel < 50) begin
      k = int'($urandom_range(0, 99));
      if (k < 75) n = CW'($urandom_range(1, 32));
      else if (k < 95) n = CW'($urandom_range(33, MAXR));
      else n = CW'($urandom_range(0, 511));
      s = SW'($urandom);
      send_item(ffba_pkg::FN_ALLOC, n, s, r);
      if (r.status == ffba_pkg::ST_OK) granted.push_back('{32'(r.first), 32'(n)});
    end else if (sel < 88 && granted.size() != 0) begin
      k = int'($urandom_range(0, granted.size() - 1));
      rr = granted[k];
      granted.delete(k);
      send_item(ffba_pkg::FN_FREE, CW'(rr.len), SW'(rr.first), r);
    end else begin
      if ($urandom_range(0, 1) == 0) begin
        n = CW'($urandom);
        s = SW'($urandom);
      end else begin
        n = CW'($urandom_range(1, 16));
        s = SW'($urandom_range(0, NBLK - 1));
      end
      send_item(ffba_pkg::FN_FREE, n, s, r);
    end
  endtask

  // Field extremes, every status and the release corner cases at the reset floor
  task automatic test_directed();
    alloc_result_t r;
    send_item(ffba_pkg::FN_ALLOC, 1, 0, r);
    send_item(ffba_pkg::FN_ALLOC, CW'(MAXR), 10'h3FF, r);
    send_item(ffba_pkg::FN_ALLOC, 0, 0, r);
    send_item(ffba_pkg::FN_ALLOC, CW'(MAXR + 1), 0, r);
    send_item(ffba_pkg::FN_ALLOC, 9'h1FF, 0, r);
    send_item(ffba_pkg::FN_FREE, 1, 0, r);
    send_item(ffba_pkg::FN_FREE, 2, 10'h3FF, r);
    send_item(ffba_pkg::FN_FREE, 1, 10'h3FF, r);
    send_item(ffba_pkg::FN_FREE, 0, 40, r);
    send_item(ffba_pkg::FN_FREE, CW'(MAXR + 1), 40, r);
    // release twice: the second pass must not touch the used count
    send_item(ffba_pkg::FN_FREE, CW'(MAXR), 33, r);
    send_item(ffba_pkg::FN_FREE, CW'(MAXR), 33, r);
    repeat (3) send_item(ffba_pkg::FN_ALLOC, CW'(MAXR), 0, r);
    send_item(ffba_pkg::FN_ALLOC, 224, 0, r);
    // punch single holes so free space exists but no run does
    send_item(ffba_pkg::FN_FREE, 1, 100, r);
    send_item(ffba_pkg::FN_ALLOC, 223, 0, r);
    send_item(ffba_pkg::FN_FREE, 1, 200, r);
    send_item(ffba_pkg::FN_ALLOC, 2, 0, r);
    for (int i = 0; i < 4; i++) send_item(ffba_pkg::FN_FREE, 248, SW'(32 + 248 * i), r);
  endtask

  // Floor at zero and at its top, with used blocks stranded below a raised floor
  task automatic test_reserved_extremes();
    alloc_result_t r;
    set_reserved(0);
    send_item(ffba_pkg::FN_ALLOC, 1, 0, r);
    send_item(ffba_pkg::FN_FREE, 1, 0, r);
    repeat (4) send_item(ffba_pkg::FN_ALLOC, CW'(MAXR), 0, r);
    send_item(ffba_pkg::FN_ALLOC, 1, 0, r);
    set_reserved(10'h3FF);
    send_item(ffba_pkg::FN_FREE, 2, 1022, r);
    send_item(ffba_pkg::FN_FREE, 1, 1023, r);
    send_item(ffba_pkg::FN_ALLOC, 1, 0, r);
    set_reserved(0);
    send_item(ffba_pkg::FN_ALLOC, 1, 0, r);
    for (int i = 0; i < 4; i++) send_item(ffba_pkg::FN_FREE, CW'(MAXR), SW'(MAXR * i), r);
    set_reserved(10'h3FF);
    send_item(ffba_pkg::FN_ALLOC, 1, 0, r);
    send_item(ffba_pkg::FN_ALLOC, 1, 0, r);
    send_item(ffba_pkg::FN_FREE, 1, 1023, r);
    set_reserved(32);
  endtask

  // Hold the result side for a long stretch while requests keep coming
  task automatic test_backpressure();
    rx_hold_cycles = 400;
    repeat (30) random_item();
    wait_idle();
    return_all_runs();
  endtask

  // Random traffic under a series of floor settings
  task automatic test_random_phases();
    int unsigned floors [7];
    floors = '{0, 32, 10'h3FF, 511, 0, 128, 0};
    floors[4] = $urandom_range(1, 1022);
    floors[6] = $urandom_range(1, 1022);
    for (int p = 0; p < 7; p++) begin
      set_reserved(RW'(floors[p]));
      // run part of phases 2 and 5 with no gaps on either side
      no_gaps = (p == 2) || (p == 5);
      repeat (120) random_item();
      no_gaps = 1'b0;
      repeat (130) random_item();
      return_all_runs();
    end
  endtask

  task automatic note_mismatch(string field, int exp, int act);
    if (mismatches < 40)
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, exp, act);
    mismatches++;
  endtask

  // Compare each accepted result against the oldest expectation
  always @(posedge clk) begin
    alloc_result_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (expected_q.size() == 0) begin
        note_mismatch("unexpected result, status", -1, int'(out_status));
      end else begin
        want = expected_q.pop_front();
        if (out_status !== want.status)
          note_mismatch("status", int'(want.status), int'(out_status));
        if (out_start_block !== want.first)
          note_mismatch("start_block", int'(want.first), int'(out_start_block));
        if (out_free_count !== want.free_cnt)
          note_mismatch("free_count", int'(want.free_cnt), int'(out_free_count));
      end
    end
  end

  // Result side: random stall per transaction, long hold on request
  initial begin
    int stall;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = draw_gap();
      if (rx_hold_cycles > 0) begin
        stall = rx_hold_cycles;
        rx_hold_cycles = 0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  // Abort a hung run
  initial begin
    #8_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    clk          = 1'b0;
    rst_n        = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    in_valid     = 1'b0;
    in_func      = ffba_pkg::FN_ALLOC;
    in_count     = '0;
    in_start_req = '0;
    no_gaps      = 1'b0;
    rx_hold_cycles = 0;
    mismatches   = 0;
    used_blocks  = 0;
    reserved_cfg = ffba_pkg::RESV_RST;
    foreach (blk_used[i]) blk_used[i] = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_reserved_extremes();
    test_backpressure();
    test_random_phases();

    // Drain, then allow for any stray result
    wait_idle();
    repeat (300) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/ffba_pkg.sv
src/ffba_scan_step.sv
src/first_fit_block_allocator.sv
src/ffba_chk.sv
tb/testbench.sv
